// ===== design/sfd_pkg.sv =====
package sfd_pkg;

  // Default frame buffer size in bytes.
  localparam int FRAME_BYTES_DEF = 1024;

  // Transport escape and framing bytes.
  localparam logic [7:0] ESC_BYTE   = 8'h1b;
  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [7:0] END_BYTE   = 8'h1a;

  // CRC-16, reflected form, with the value it holds after the start sequence.
  localparam logic [15:0] CRC_START = 16'h91dc;
  localparam logic [15:0] CRC_POLY  = 16'h8408;

  // Fixed widths of the result fields.
  localparam int LEN_W   = 11;
  localparam int COUNT_W = 32;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Overhead bytes removed from the payload length besides the padding.
  localparam int TRAILER_BYTES = 8;

  // Packed widths of the stream words.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 2;

  // One byte through the reflected CRC, one bit a step.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== design/sml_frame_deframer_core.sv =====
// Deframer for the SML transport layer. It takes one byte per word on the input
// stream, hunts for the start sequence (four 0x1b bytes then four 0x01 bytes),
// and then passes every frame byte out, trailer, padding count and CRC bytes
// included; start bytes produce no output word. On the low CRC byte the word
// carries tlast, the CRC check result, the payload length (bytes minus eight
// minus padding, held between 0 and 2047) and the running good and bad frame
// counts. A frame longer than FRAME_BYTES ends with a word that has tlast and
// the overflow flag set, and the deframer resumes hunting. The block takes one
// byte per clock cycle: the byte-wide CRC update and the frame state machine
// both finish within the cycle of acceptance, and a single output register
// holds the result, so in_tready drops only while that register is full and
// out_tready is low. An output word appears in the cycle after its byte is accepted.
module sml_frame_deframer_core
  import sfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] frame_byte, [18:8] payload_length,
                                            // [50:19] good_count, [82:51] bad_count,
                                            // [87:83] zero
  output logic [OUT_USER_W-1:0] out_tuser,  // [0] crc_good, [1] overflow
  output logic                  out_tlast   // frame_last
);

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int DW = ((CW > 9) ? CW : 9) + 1;

  // Hunt and frame states: escapes, start bytes, escape counting, then trailer.
  typedef enum logic [3:0] {
    ST_ESC0, ST_ESC1, ST_ESC2, ST_ESC3,
    ST_SYN0, ST_SYN1, ST_SYN2, ST_SYN3,
    ST_FRM0, ST_FRM1, ST_FRM2, ST_FRM3, ST_FRM4,
    ST_PAD, ST_CRCH, ST_CRCL
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        byte_count_r, byte_count_nxt;
  logic [7:0]           padding_r, padding_nxt;
  logic [15:0]          crc_r, crc_nxt;
  logic [7:0]           crc_high_r, crc_high_nxt;
  logic [COUNT_W-1:0]   good_r, good_nxt;
  logic [COUNT_W-1:0]   bad_r, bad_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           o_byte_r, o_byte_nxt;
  logic                 o_last_r, o_last_nxt;
  logic                 o_good_r, o_good_nxt;
  logic                 o_ovf_r, o_ovf_nxt;
  logic [LEN_W-1:0]     o_len_r, o_len_nxt;

  logic                 accept;
  logic [7:0]           c;
  logic [CW-1:0]        bc_inc;
  logic [15:0]          crc_fin;
  logic [15:0]          crc_calc;
  logic [DW-1:0]        sub;
  logic [DW-1:0]        bc_ext;
  logic [DW-1:0]        diff;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign c         = in_tdata[7:0];

  // Length and CRC check terms for the final byte.
  assign bc_inc   = byte_count_r + CW'(1);
  assign crc_fin  = ~crc_r;
  assign crc_calc = {crc_fin[7:0], crc_fin[15:8]};
  assign sub      = DW'(TRAILER_BYTES) + DW'(padding_r);
  assign bc_ext   = DW'(bc_inc);
  assign diff     = bc_ext - sub;

  // Next state and result word for one accepted byte.
  always_comb begin
    state_nxt      = state_r;
    byte_count_nxt = byte_count_r;
    padding_nxt    = padding_r;
    crc_nxt        = crc_r;
    crc_high_nxt   = crc_high_r;
    good_nxt       = good_r;
    bad_nxt        = bad_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    o_byte_nxt     = o_byte_r;
    o_last_nxt     = o_last_r;
    o_good_nxt     = o_good_r;
    o_ovf_nxt      = o_ovf_r;
    o_len_nxt      = o_len_r;

    if (accept) begin
      if (state_r inside {[ST_ESC0:ST_SYN3]}) begin
        // Hunting: no output word.
        if (state_r inside {[ST_SYN0:ST_SYN3]} && c == START_BYTE) begin
          state_nxt = state_t'(state_r + 4'd1);
          if (state_r == ST_SYN3) begin
            byte_count_nxt = '0;
            crc_nxt        = CRC_START;
          end
        end else if (state_r inside {[ST_SYN0:ST_SYN3]}) begin
          // A broken start sequence counts this byte as a new first byte.
          state_nxt = (c == ESC_BYTE) ? ST_ESC1 : ST_ESC0;
        end else begin
          state_nxt = (c == ESC_BYTE) ? state_t'(state_r + 4'd1) : ST_ESC0;
        end
      end else begin
        out_valid_nxt = 1'b1;
        o_byte_nxt    = c;
        o_last_nxt    = 1'b0;
        o_good_nxt    = 1'b0;
        o_ovf_nxt     = 1'b0;
        o_len_nxt     = '0;
        if (byte_count_r >= CW'(FRAME_BYTES)) begin
          // Buffer full: abort the frame and hunt again.
          o_last_nxt     = 1'b1;
          o_ovf_nxt      = 1'b1;
          state_nxt      = ST_ESC0;
          byte_count_nxt = '0;
          crc_nxt        = CRC_START;
        end else begin
          byte_count_nxt = bc_inc;
          if (state_r != ST_CRCH && state_r != ST_CRCL) begin
            crc_nxt = crc_byte(crc_r, c);
          end
          case (state_r)
            ST_FRM0, ST_FRM1, ST_FRM2, ST_FRM3: begin
              state_nxt = (c == ESC_BYTE) ? state_t'(state_r + 4'd1) : ST_FRM0;
            end
            ST_FRM4: begin
              if (c == END_BYTE) begin
                state_nxt = ST_PAD;
              end else begin
                state_nxt = (c == ESC_BYTE) ? ST_FRM1 : ST_FRM0;
              end
            end
            ST_PAD: begin
              padding_nxt = c;
              state_nxt   = ST_CRCH;
            end
            ST_CRCH: begin
              crc_high_nxt = c;
              state_nxt    = ST_CRCL;
            end
            ST_CRCL: begin
              // Frame end: check CRC, report length, count the frame.
              o_last_nxt = 1'b1;
              if ({crc_high_r, c} == crc_calc) begin
                o_good_nxt = 1'b1;
                good_nxt   = good_r + COUNT_W'(1);
              end else begin
                bad_nxt = bad_r + COUNT_W'(1);
              end
              if (bc_ext <= sub) begin
                o_len_nxt = '0;
              end else if (diff > DW'(LEN_MAX)) begin
                o_len_nxt = LEN_MAX;
              end else begin
                o_len_nxt = diff[LEN_W-1:0];
              end
              state_nxt      = ST_ESC0;
              byte_count_nxt = '0;
              crc_nxt        = CRC_START;
            end
            default: begin
              state_nxt = ST_ESC0;
            end
          endcase
        end
      end
    end
  end

  // Control state, counters and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_ESC0;
      byte_count_r <= '0;
      padding_r    <= '0;
      crc_r        <= CRC_START;
      crc_high_r   <= '0;
      good_r       <= '0;
      bad_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      byte_count_r <= byte_count_nxt;
      padding_r    <= padding_nxt;
      crc_r        <= crc_nxt;
      crc_high_r   <= crc_high_nxt;
      good_r       <= good_nxt;
      bad_r        <= bad_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    o_byte_r <= o_byte_nxt;
    o_last_r <= o_last_nxt;
    o_good_r <= o_good_nxt;
    o_ovf_r  <= o_ovf_nxt;
    o_len_r  <= o_len_nxt;
  end

  // The counts are sampled with the word they belong to.
  logic [COUNT_W-1:0] o_good_cnt_r, o_bad_cnt_r;
  always_ff @(posedge clk) begin
    if (accept) begin
      o_good_cnt_r <= good_nxt;
      o_bad_cnt_r  <= bad_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tuser  = {o_ovf_r, o_good_r};
  assign out_tdata  = {5'b00000, o_bad_cnt_r, o_good_cnt_r, o_len_r, o_byte_r};

endmodule

// ===== test/tb_sml_frame_deframer_core.sv =====
`timescale 1ns / 1ps

module tb_sml_frame_deframer_core
  import sfd_pkg::*;
();

  localparam int FRAME_LEN = FRAME_BYTES_DEF;
  localparam int QUIET_LIMIT = 1000;

  // Hunt phases: 0..7 look for the start sequence, 8..12 count escape bytes,
  // then padding count, CRC high byte and CRC low byte.
  localparam logic [3:0] PH_HUNT = 4'd0;
  localparam logic [3:0] PH_FIRST_START = 4'd4;
  localparam logic [3:0] PH_SYNCED = 4'd8;
  localparam logic [3:0] PH_ONE_ESC = 4'd9;
  localparam logic [3:0] PH_LAST_ESC = 4'd11;
  localparam logic [3:0] PH_FOUR_ESC = 4'd12;
  localparam logic [3:0] PH_PAD = 4'd13;
  localparam logic [3:0] PH_CRC_HI = 4'd14;

  // One output word split into its fields.
  typedef struct packed {
    logic [4:0]         spare;
    logic [COUNT_W-1:0] bad_count;
    logic [COUNT_W-1:0] good_count;
    logic [LEN_W-1:0]   payload_length;
    logic [7:0]         frame_byte;
    logic               frame_last;
    logic               crc_good;
    logic               overflow;
  } frame_word_t;

  // Deframer model plus the queue of words it predicts.
  class deframe_book;
    logic [3:0]         phase;
    logic [LEN_W-1:0]   count;
    logic [7:0]         pad;
    logic [15:0]        crc;
    logic [7:0]         crc_hi;
    logic [COUNT_W-1:0] good_n;
    logic [COUNT_W-1:0] bad_n;
    frame_word_t        due_words[$];
    int unsigned        bytes_noted;
    int unsigned        words_made;
    int unsigned        faults;

    function new();
      restart();
      pad = '0;
      crc_hi = '0;
      good_n = '0;
      bad_n = '0;
      bytes_noted = 0;
      words_made = 0;
      faults = 0;
    endfunction

    static function logic [15:0] crc_feed(logic [15:0] crc_in, logic [7:0] b);
      logic [15:0] r;
      r = crc_in ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
    endfunction

    function void restart();
      phase = PH_HUNT;
      count = '0;
      crc = CRC_START;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    // Advance the model by one accepted byte and queue the word it causes.
    function void note_byte(logic [7:0] b);
      logic [3:0]  st;
      frame_word_t w;
      logic [15:0] fin;
      int unsigned len;
      bytes_noted++;
      if (phase < PH_SYNCED) begin
        if (phase >= PH_FIRST_START && b == START_BYTE) begin
          phase = phase + 4'd1;
          if (phase == PH_SYNCED) begin
            count = '0;
            crc = CRC_START;
          end
          return;
        end
        // A broken start sequence counts the byte as the start of a new hunt.
        st = (phase >= PH_FIRST_START) ? PH_HUNT : phase;
        if (st == PH_HUNT) restart();
        phase = (b == ESC_BYTE) ? st + 4'd1 : PH_HUNT;
        return;
      end

      w = '0;
      w.frame_byte = b;
      if (count >= FRAME_LEN) begin
        // Buffer full: abort the frame without touching the counters.
        w.frame_last = 1'b1;
        w.overflow = 1'b1;
        restart();
      end else begin
        count = count + 1'b1;
        st = phase;
        if (st <= PH_LAST_ESC) begin
          phase = (b == ESC_BYTE) ? st + 4'd1 : PH_SYNCED;
        end else if (st == PH_FOUR_ESC) begin
          if (b == END_BYTE) phase = PH_PAD;
          else phase = (b == ESC_BYTE) ? PH_ONE_ESC : PH_SYNCED;
        end else if (st == PH_PAD) begin
          pad = b;
          phase = PH_CRC_HI;
        end else if (st == PH_CRC_HI) begin
          crc_hi = b;
          phase = st + 4'd1;
        end else begin
          // Low CRC byte: compare, count and report the payload length.
          fin = ~crc;
          w.frame_last = 1'b1;
          if ({crc_hi, b} == {fin[7:0], fin[15:8]}) begin
            w.crc_good = 1'b1;
            good_n = good_n + 1'b1;
          end else begin
            bad_n = bad_n + 1'b1;
          end
          len = (count > 8 + pad) ? count - 8 - pad : 0;
          w.payload_length = (len > LEN_MAX) ? LEN_MAX : len[LEN_W-1:0];
          restart();
        end
        if (st <= PH_PAD) crc = crc_feed(crc, b);
      end
      w.good_count = good_n;
      w.bad_count = bad_n;
      due_words.push_back(w);
      words_made++;
    endfunction

    function void complain(string why, frame_word_t want, frame_word_t got);
      faults++;
      if (faults <= 10)
        $display("%s: want byte %02h last %0d good %0d ovf %0d len %0d cnt %0d/%0d pad %0h;",
                 why, want.frame_byte, want.frame_last, want.crc_good, want.overflow,
                 want.payload_length, want.good_count, want.bad_count, want.spare,
                 "  got byte %02h last %0d good %0d ovf %0d len %0d cnt %0d/%0d pad %0h",
                 got.frame_byte, got.frame_last, got.crc_good, got.overflow,
                 got.payload_length, got.good_count, got.bad_count, got.spare);
    endfunction

    // Compare one accepted output word with the oldest prediction.
    function void check_word(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user,
                             logic last);
      frame_word_t got;
      frame_word_t want;
      got.frame_byte = data[7:0];
      got.payload_length = data[18:8];
      got.good_count = data[50:19];
      got.bad_count = data[82:51];
      got.spare = data[87:83];
      got.crc_good = user[0];
      got.overflow = user[1];
      got.frame_last = last;
      if (due_words.size() == 0) begin
        complain("unexpected word", '0, got);
        return;
      end
      want = due_words.pop_front();
      if (got !== want) complain("word mismatch", want, got);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  deframe_book book;
  logic [7:0]  body_q[$];
  int          send_gap_odds = 0;
  int          sink_stall_odds = 0;
  bit          calm = 1'b0;
  int          quiet = 0;

  sml_frame_deframer_core #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  // Monitor both channels at the rising edge; results are checked before
  // the same edge's input is noted. Also watch for a stuck block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) book.check_word(out_tdata, out_tuser, out_tlast);
      if (in_tvalid && in_tready) book.note_byte(in_tdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("tb_sml_frame_deframer_core failed");
          $finish;
        end
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off that backs up the input.
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    out_tready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    out_tready <= 1'b1;
    forever begin
      @(negedge clk);
      if (!hold_done && book.bytes_noted >= 100) begin
        out_tready <= 1'b0;
        repeat (80) @(negedge clk);
        out_tready <= 1'b1;
        hold_done = 1'b1;
      end else if (!calm && sink_stall_odds != 0 &&
                   $urandom_range(1, sink_stall_odds) == 1) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one word, possibly after a gap, and return at the falling edge
  // after it was taken.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending until every predicted word has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (book.pending() != 0) @(negedge clk);
  endtask

  task automatic fill_body(input int len, input int esc_pct);
    body_q.delete();
    repeat (len)
      body_q.push_back(($urandom_range(0, 99) < esc_pct) ? ESC_BYTE :
                       8'($urandom_range(0, 255)));
  endtask

  // A byte that is neither an escape nor a start byte puts the hunt back to zero.
  task automatic send_settle();
    send_byte(8'($urandom_range(2, 26)));
  endtask

  // Start sequence, body_q, trailer, padding count and CRC (spoiled if asked).
  task automatic send_frame(input logic [7:0] pad, input bit spoil);
    logic [15:0] crc;
    logic [15:0] chk;
    crc = CRC_START;
    repeat (4) send_byte(ESC_BYTE);
    repeat (4) send_byte(START_BYTE);
    foreach (body_q[i]) begin
      send_byte(body_q[i]);
      crc = deframe_book::crc_feed(crc, body_q[i]);
    end
    repeat (4) begin
      send_byte(ESC_BYTE);
      crc = deframe_book::crc_feed(crc, ESC_BYTE);
    end
    send_byte(END_BYTE);
    crc = deframe_book::crc_feed(crc, END_BYTE);
    send_byte(pad);
    crc = deframe_book::crc_feed(crc, pad);
    crc = ~crc;
    chk = {crc[7:0], crc[15:8]};
    if (spoil) chk = chk ^ (16'd1 << $urandom_range(0, 15));
    send_byte(chk[15:8]);
    send_byte(chk[7:0]);
  endtask

  initial begin : stimulus
    int round;
    int mark;
    int bulk_words;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    round = 0;
    bulk_words = 0;
    book = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Hunting noise, then a start sequence broken by an escape byte.
    send_byte(8'h00);
    send_byte(8'hff);
    repeat (4) send_byte(ESC_BYTE);
    repeat (2) send_byte(START_BYTE);
    send_byte(ESC_BYTE);
    send_settle();
    // Shortest frame: empty body, no padding, good CRC.
    body_q.delete();
    send_frame(8'd0, 1'b0);
    // Escape runs in the body: four escapes then a plain byte, and a fifth
    // escape restarting the count; padding larger than the whole frame.
    body_q = '{ESC_BYTE, ESC_BYTE, ESC_BYTE, ESC_BYTE, 8'h00,
               ESC_BYTE, ESC_BYTE, ESC_BYTE, ESC_BYTE, ESC_BYTE, 8'h55};
    send_frame(8'hff, 1'b0);
    // One payload byte with a bad CRC.
    body_q = '{8'hff};
    send_frame(8'd0, 1'b1);
    drain();

    // Random part, mostly well-formed frames with random content.
    while (book.words_made - bulk_words < 640) begin
      round++;
      send_gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
      sink_stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
      if (book.words_made - bulk_words >= 520) calm = 1'b1;
      if (round == 6 || round == 14 || round == 22) begin
        // Rare long frames: exactly full, one byte too many, and no trailer.
        mark = book.words_made;
        if (round == 22) begin
          repeat (4) send_byte(ESC_BYTE);
          repeat (4) send_byte(START_BYTE);
          repeat (FRAME_LEN + 40) send_byte(8'($urandom_range(0, 255)));
          send_settle();
        end else begin
          fill_body((round == 6) ? FRAME_LEN - 8 : FRAME_LEN - 7, 0);
          send_frame(8'd0, 1'b0);
        end
        bulk_words += book.words_made - mark;
      end else if (round % 9 == 4) begin
        drain();
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, 10)) begin
              case ($urandom_range(0, 3))
                0: send_byte(ESC_BYTE);
                1: send_byte(START_BYTE);
                default: send_byte(8'($urandom_range(0, 255)));
              endcase
            end
            send_settle();
          end
          1: begin
            repeat ($urandom_range(1, 4)) send_byte(ESC_BYTE);
            repeat ($urandom_range(0, 3)) send_byte(START_BYTE);
            send_settle();
          end
          default: begin
            fill_body(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) :
                      $urandom_range(4, 40),
                      ($urandom_range(0, 3) == 0) ? 35 : 0);
            send_frame(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                       8'($urandom_range(0, 3)),
                       $urandom_range(0, 3) == 0);
          end
        endcase
      end
    end

    // Let every predicted word come out, then a few more cycles.
    in_tvalid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (book.faults == 0 && book.pending() == 0) begin
      $display("tb_sml_frame_deframer_core passed");
    end else begin
      $display("tb_sml_frame_deframer_core failed");
    end
    $finish;
  end

endmodule
